// ===== sv/point_to_line_distance_3d_unit_assert.svh =====
// assertion macros for the point to line distance unit
// no dependencies; included by the top level only
`ifndef POINT_TO_LINE_DISTANCE_3D_UNIT_ASSERT_SVH
`define POINT_TO_LINE_DISTANCE_3D_UNIT_ASSERT_SVH

// same-cycle implication
`define PTLD_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ptld assertion failed");

// next-cycle implication
`define PTLD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ptld assertion failed");

`endif

// ===== sv/ptld_pkg.sv =====
// shared types and constants for the point to line distance unit
// no dependencies
package ptld_pkg;

  localparam int COORD_BITS_DEF = 18;
  localparam int FRAC_BITS_DEF  = 6;
  localparam int DEGEN_SCALE    = 10000;

  typedef enum logic [2:0] {
    CFG_END_A_X     = 3'd0,
    CFG_END_A_Y     = 3'd1,
    CFG_END_A_Z     = 3'd2,
    CFG_END_B_X     = 3'd3,
    CFG_END_B_Y     = 3'd4,
    CFG_END_B_Z     = 3'd5,
    CFG_LINE_LENGTH = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic degen;
    logic ovf;
  } ctl_t;

endpackage

// ===== sv/ptld_front.sv =====
// front end: offsets, cross product (offset to end A for a degenerate line), squared magnitude
// depends on ptld_pkg
module ptld_front #(
  parameter int COORD_BITS = ptld_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ptld_pkg::ctl_t                   ctl_i,
  input  logic signed [COORD_BITS-1:0]     px,
  input  logic signed [COORD_BITS-1:0]     py,
  input  logic signed [COORD_BITS-1:0]     pz,
  input  logic signed [COORD_BITS-1:0]     ax,
  input  logic signed [COORD_BITS-1:0]     ay,
  input  logic signed [COORD_BITS-1:0]     az,
  input  logic signed [COORD_BITS-1:0]     bx,
  input  logic signed [COORD_BITS-1:0]     by,
  input  logic signed [COORD_BITS-1:0]     bz,
  output ptld_pkg::ctl_t                   ctl_o,
  output logic [4*COORD_BITS+5:0]          sum_o
);
  import ptld_pkg::*;

  localparam int D  = COORD_BITS + 1;
  localparam int PW = 2 * D;
  localparam int M  = PW;
  localparam int H  = (M + 1) / 2;
  localparam int HB = M - H;
  localparam int SW = 2 * M + 2;

  ctl_t                 ctl_r [6];
  logic signed [D-1:0]  da_r [3];
  logic signed [D-1:0]  db_r [3];
  logic signed [D-1:0]  da2_r [3];
  logic signed [PW-1:0] prod_r [6];
  logic [M-1:0]         vec_r [3];
  logic [M-1:0]         vec_nxt [3];
  logic [2*HB-1:0]      hh_r [3];
  logic [H+HB-1:0]      hl_r [3];
  logic [2*H-1:0]       ll_r [3];
  logic [2*M-1:0]       sq_r [3];
  logic [SW-1:0]        sum_r;
  logic signed [PW:0]   cr [3];
  logic signed [PW:0]   cr_mag [3];
  logic signed [D:0]    de [3];
  logic signed [D:0]    de_mag [3];

  always_comb begin
    cr[0] = (PW+1)'(prod_r[0]) - (PW+1)'(prod_r[1]);
    cr[1] = (PW+1)'(prod_r[2]) - (PW+1)'(prod_r[3]);
    cr[2] = (PW+1)'(prod_r[4]) - (PW+1)'(prod_r[5]);
    for (int i = 0; i < 3; i++) begin
      cr_mag[i] = (cr[i] < 0) ? -cr[i] : cr[i];
      de[i]     = (D+1)'(da2_r[i]);
      de_mag[i] = (de[i] < 0) ? -de[i] : de[i];
      if (ctl_r[1].degen) begin
        vec_nxt[i] = M'($unsigned(de_mag[i][D-1:0]));
      end else begin
        vec_nxt[i] = $unsigned(cr_mag[i][M-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) ctl_r[i] <= '0;
    end else begin
      ctl_r[0] <= ctl_i;
      for (int i = 1; i < 6; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    da_r[0] <= D'(px) - D'(ax);
    da_r[1] <= D'(py) - D'(ay);
    da_r[2] <= D'(pz) - D'(az);
    db_r[0] <= D'(px) - D'(bx);
    db_r[1] <= D'(py) - D'(by);
    db_r[2] <= D'(pz) - D'(bz);
    da2_r     <= da_r;
    prod_r[0] <= da_r[1] * db_r[2];
    prod_r[1] <= da_r[2] * db_r[1];
    prod_r[2] <= da_r[2] * db_r[0];
    prod_r[3] <= da_r[0] * db_r[2];
    prod_r[4] <= da_r[0] * db_r[1];
    prod_r[5] <= da_r[1] * db_r[0];
    vec_r <= vec_nxt;
    for (int i = 0; i < 3; i++) begin
      hh_r[i] <= vec_r[i][M-1:H] * vec_r[i][M-1:H];
      hl_r[i] <= vec_r[i][M-1:H] * vec_r[i][H-1:0];
      ll_r[i] <= vec_r[i][H-1:0] * vec_r[i][H-1:0];
      sq_r[i] <= ((2*M)'(hh_r[i]) << (2*H)) + ((2*M)'(hl_r[i]) << (H+1))
               + (2*M)'(ll_r[i]);
    end
    sum_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
  end

  assign ctl_o = ctl_r[5];
  assign sum_o = sum_r;

endmodule

// ===== sv/ptld_sqrt_cell.sv =====
// one digit cell of the restoring square root chain
// depends on ptld_pkg
module ptld_sqrt_cell #(
  parameter int RW = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ptld_pkg::ctl_t   ctl_i,
  input  logic [2*RW-1:0]  x_i,
  input  logic [RW+2:0]    rem_i,
  input  logic [RW-1:0]    root_i,
  output ptld_pkg::ctl_t   ctl_o,
  output logic [2*RW-1:0]  x_o,
  output logic [RW+2:0]    rem_o,
  output logic [RW-1:0]    root_o
);
  import ptld_pkg::*;

  localparam int RMW = RW + 3;

  logic [RMW-1:0] rem_s;
  logic [RMW-1:0] trial;
  logic           ge;

  always_comb begin
    rem_s = {rem_i[RMW-3:0], x_i[2*RW-1 -: 2]};
    trial = RMW'({root_i, 2'b01});
    ge    = rem_s >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    x_o    <= {x_i[2*RW-3:0], 2'b00};
    rem_o  <= ge ? rem_s - trial : rem_s;
    root_o <= {root_i[RW-2:0], ge};
  end

endmodule

// ===== sv/ptld_div_cell.sv =====
// one quotient bit cell of the restoring divider chain
// depends on ptld_pkg
module ptld_div_cell #(
  parameter int RW = 40,
  parameter int QB = 20
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ptld_pkg::ctl_t  ctl_i,
  input  logic [RW-1:0]   rem_i,
  input  logic [RW-1:0]   dvs_i,
  input  logic [QB-1:0]   q_i,
  output ptld_pkg::ctl_t  ctl_o,
  output logic [RW-1:0]   rem_o,
  output logic [RW-1:0]   dvs_o,
  output logic [QB-1:0]   q_o
);
  import ptld_pkg::*;

  logic ge;

  assign ge = rem_i >= dvs_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_o <= ge ? rem_i - dvs_i : rem_i;
    dvs_o <= dvs_i >> 1;
    q_o   <= {q_i[QB-2:0], ge};
  end

endmodule

// ===== sv/point_to_line_distance_3d_unit.sv =====
// an accepted item passes the front end, root cells, divider input register, divider cells and output register
// throughput: one item per cycle, busy stays low; set by the root and divider cell chains
// results appear for one cycle on out_strobe, the receiver cannot stall
// synchronous active-low reset clears the valid bits and the line registers to zero
// depends on ptld_pkg, ptld_front, ptld_sqrt_cell, ptld_div_cell
module point_to_line_distance_3d_unit #(
  parameter int COORD_BITS = ptld_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ptld_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_point_x,
  input  logic signed [COORD_BITS-1:0]  in_point_y,
  input  logic signed [COORD_BITS-1:0]  in_point_z,
  output logic                          out_strobe,
  output logic [COORD_BITS:0]           out_distance,
  output logic                          out_used_endpoint,
  output logic                          out_saturated,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [COORD_BITS:0]           cfg_data
);
  import ptld_pkg::*;

  localparam int     D         = COORD_BITS + 1;
  localparam int     M         = 2 * D;
  localparam int     SW        = 2 * M + 2;
  localparam int     RW        = M + 2;
  localparam int     QB        = D + 1;
  localparam longint DEGEN_LIM = ((64'd1 << FRAC_BITS) + DEGEN_SCALE - 1) / DEGEN_SCALE;
  localparam int     LAT       = 8 + RW + QB;

  logic signed [COORD_BITS-1:0] end_a_x_r, end_a_y_r, end_a_z_r;
  logic signed [COORD_BITS-1:0] end_b_x_r, end_b_y_r, end_b_z_r;
  logic [D-1:0]                 line_length_r;

  logic     in_acc;
  logic     degen_w;
  ctl_t     front_ctl;
  logic [SW-1:0] front_sum;

  ctl_t          sq_ctl  [RW+1];
  logic [2*RW-1:0] sq_x  [RW+1];
  logic [RW+2:0] sq_rem  [RW+1];
  logic [RW-1:0] sq_root [RW+1];

  ctl_t          dv_ctl [QB+1];
  logic [RW-1:0] dv_rem [QB+1];
  logic [RW-1:0] dv_dvs [QB+1];
  logic [QB-1:0] dv_q   [QB+1];

  logic [D-1:0]  leff;
  logic [QB:0]   qp1;
  logic [QB-1:0] c_w;
  logic          sat_w;

  assign busy    = 1'b0;
  assign in_acc  = start && !busy;
  assign degen_w = 64'(line_length_r) < 64'(DEGEN_LIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_a_x_r     <= '0;
      end_a_y_r     <= '0;
      end_a_z_r     <= '0;
      end_b_x_r     <= '0;
      end_b_y_r     <= '0;
      end_b_z_r     <= '0;
      line_length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_END_A_X:     end_a_x_r     <= cfg_data[COORD_BITS-1:0];
        CFG_END_A_Y:     end_a_y_r     <= cfg_data[COORD_BITS-1:0];
        CFG_END_A_Z:     end_a_z_r     <= cfg_data[COORD_BITS-1:0];
        CFG_END_B_X:     end_b_x_r     <= cfg_data[COORD_BITS-1:0];
        CFG_END_B_Y:     end_b_y_r     <= cfg_data[COORD_BITS-1:0];
        CFG_END_B_Z:     end_b_z_r     <= cfg_data[COORD_BITS-1:0];
        CFG_LINE_LENGTH: line_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ptld_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i ('{valid: in_acc, degen: degen_w, ovf: 1'b0}),
    .px    (in_point_x),
    .py    (in_point_y),
    .pz    (in_point_z),
    .ax    (end_a_x_r),
    .ay    (end_a_y_r),
    .az    (end_a_z_r),
    .bx    (end_b_x_r),
    .by    (end_b_y_r),
    .bz    (end_b_z_r),
    .ctl_o (front_ctl),
    .sum_o (front_sum)
  );

  assign sq_ctl[0]  = front_ctl;
  assign sq_x[0]    = {front_sum, 2'b00};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    ptld_sqrt_cell #(.RW(RW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (sq_ctl[i]),
      .x_i    (sq_x[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .ctl_o  (sq_ctl[i+1]),
      .x_o    (sq_x[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  // divisor is one for a degenerate line
  assign leff = sq_ctl[RW].degen ? D'(1) : line_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctl[0] <= '0;
    end else begin
      dv_ctl[0].valid <= sq_ctl[RW].valid;
      dv_ctl[0].degen <= sq_ctl[RW].degen;
      dv_ctl[0].ovf   <= sq_root[RW] >= (RW'(leff) << QB);
    end
  end

  always_ff @(posedge clk) begin
    dv_rem[0] <= sq_root[RW];
    dv_dvs[0] <= RW'(leff) << (QB - 1);
    dv_q[0]   <= '0;
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    ptld_div_cell #(.RW(RW), .QB(QB)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (dv_ctl[i]),
      .rem_i (dv_rem[i]),
      .dvs_i (dv_dvs[i]),
      .q_i   (dv_q[i]),
      .ctl_o (dv_ctl[i+1]),
      .rem_o (dv_rem[i+1]),
      .dvs_o (dv_dvs[i+1]),
      .q_o   (dv_q[i+1])
    );
  end

  // round half up: (q + 1) / 2
  always_comb begin
    qp1   = (QB+1)'(dv_q[QB]) + (QB+1)'(1);
    c_w   = qp1[QB:1];
    sat_w = dv_ctl[QB].ovf || c_w[QB-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe        <= 1'b0;
      out_used_endpoint <= 1'b0;
      out_saturated     <= 1'b0;
    end else begin
      out_strobe        <= dv_ctl[QB].valid;
      out_used_endpoint <= dv_ctl[QB].valid && dv_ctl[QB].degen;
      out_saturated     <= dv_ctl[QB].valid && sat_w;
    end
  end

  always_ff @(posedge clk) begin
    out_distance <= sat_w ? '1 : c_w[D-1:0];
  end

`include "point_to_line_distance_3d_unit_assert.svh"

  `PTLD_ASSERT_IMPL(a_sat_max, clk, rst_n, out_saturated, out_strobe && (out_distance == '1))
  `PTLD_ASSERT_IMPL(a_latency, clk, rst_n, out_strobe, $past(in_acc, LAT))
  `PTLD_ASSERT_NEXT(a_root_to_div, clk, rst_n, sq_ctl[RW].valid, dv_ctl[0].valid)
  `PTLD_ASSERT_IMPL(a_endpoint, clk, rst_n, out_used_endpoint, out_strobe && degen_w)

endmodule
